// File: src/lla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg - shared types and constants for the life-like automaton row step
// register indexes, reset values and the result entry layout
// ----------------------------------------------------------------------------
package lla_pkg;

   localparam int ROW_BITS          = 64;
   localparam int MAX_WIDTH_DEFAULT = 64;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 9;
   localparam int RULE_BITS         = 9;
   localparam int WIDTH_REG_BITS    = 7;

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_WIDTH    = 2'd0,
      CSR_BIRTH_MASK   = 2'd1,
      CSR_SURVIVE_MASK = 2'd2
   } csr_index_type;

   localparam logic [WIDTH_REG_BITS-1:0] ROW_WIDTH_RESET    = 7'd64;
   localparam logic [RULE_BITS-1:0]      BIRTH_MASK_RESET   = 9'd480;
   localparam logic [RULE_BITS-1:0]      SURVIVE_MASK_RESET = 9'd480;

   // one queued result row
   typedef struct packed {
      logic [ROW_BITS-1:0] cells;
      logic                grid_end;
      logic                run_end;
   } result_type;

endpackage

// File: src/life_like_automaton_row_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_row_step - one generation of a life-like automaton
// streams grid rows in, emits next-generation rows one row behind
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   req     | in        | req_valid/req_stall | req_row_cells, req_last_row
//   rsp     | out       | rsp_valid/rsp_stall | rsp_next_cells, rsp_grid_end,
//           |           |                     | rsp_run_end
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// a row transaction is registered, then the neighbor count and rule lookup
// run combinationally and the results enter a two-entry result queue
// one row per cycle sustained; a bottom row gives two results, and the extra
// one drains while the next grid's top row (which gives none) passes, so the
// input side only waits while rsp_stall leaves no room in the queue for a row's results
// each result is registered in the queue before it reaches the output
// synchronous active-high reset clears the queue, the input register and
// the grid state; rsp_stall backs up through the queue into req_stall
// ----------------------------------------------------------------------------
module life_like_automaton_row_step #(
   parameter int MAX_WIDTH = lla_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // row input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lla_pkg::ROW_BITS-1:0]      req_row_cells,
   input  logic                              req_last_row,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lla_pkg::ROW_BITS-1:0]      rsp_next_cells,
   output logic                              rsp_grid_end,
   output logic                              rsp_run_end,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lla_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lla_pkg::*;

   localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);

   // ---------------------------------------------------------------------
   // next generation of the middle row; cells outside the in-use width and
   // the left and right edges count as alive
   // ---------------------------------------------------------------------
   function automatic logic [MAX_WIDTH-1:0] next_row(
      input logic [MAX_WIDTH-1:0] up,
      input logic [MAX_WIDTH-1:0] mid,
      input logic [MAX_WIDTH-1:0] down,
      input logic [MAX_WIDTH-1:0] in_use,
      input logic [RULE_BITS-1:0] birth,
      input logic [RULE_BITS-1:0] survive
   );
      logic [MAX_WIDTH+1:0] up_pad;
      logic [MAX_WIDTH+1:0] mid_pad;
      logic [MAX_WIDTH+1:0] down_pad;
      logic [MAX_WIDTH-1:0] res;
      logic [3:0]           count;
      up_pad   = {1'b1, up   | ~in_use, 1'b1};
      mid_pad  = {1'b1, mid  | ~in_use, 1'b1};
      down_pad = {1'b1, down | ~in_use, 1'b1};
      for (int x = 0; x < MAX_WIDTH; x++) begin
         // pad index x+1 is column x
         count = 4'(up_pad[x])   + 4'(up_pad[x+1])   + 4'(up_pad[x+2])
               + 4'(mid_pad[x])                      + 4'(mid_pad[x+2])
               + 4'(down_pad[x]) + 4'(down_pad[x+1]) + 4'(down_pad[x+2]);
         res[x] = mid_pad[x+1] ? survive[count] : birth[count];
      end
      return res & in_use;
   endfunction

   // ---------------------------------------------------------------------
   // configuration registers, always ready
   // ---------------------------------------------------------------------
   logic [WIDTH_REG_BITS-1:0] row_width_ff;
   logic [RULE_BITS-1:0]      birth_mask_ff;
   logic [RULE_BITS-1:0]      survive_mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= ROW_WIDTH_RESET;
         birth_mask_ff   <= BIRTH_MASK_RESET;
         survive_mask_ff <= SURVIVE_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_WIDTH:    row_width_ff    <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_BIRTH_MASK:   birth_mask_ff   <= csr_wdata;
            CSR_SURVIVE_MASK: survive_mask_ff <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // effective width clamped to 1..MAX_WIDTH, then the in-use cell mask
   logic [WIDTH_BITS-1:0] eff_width;
   logic [MAX_WIDTH-1:0]  use_mask;

   always_comb begin
      priority if (row_width_ff == '0) begin
         eff_width = WIDTH_BITS'(1);
      end else if (row_width_ff > WIDTH_REG_BITS'(MAX_WIDTH)) begin
         eff_width = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_width = WIDTH_BITS'(row_width_ff);
      end
      for (int x = 0; x < MAX_WIDTH; x++) begin
         use_mask[x] = (WIDTH_BITS'(x) < eff_width);
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic [MAX_WIDTH-1:0] s1_cells_ff;
   logic                 s1_last_ff;
   logic                 s1_fire;
   logic                 req_take;

   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cells_ff <= req_row_cells[MAX_WIDTH-1:0];
         s1_last_ff  <= req_last_row;
      end
   end

   // ---------------------------------------------------------------------
   // grid state: row above the pending row, and the pending row itself
   // ---------------------------------------------------------------------
   logic [MAX_WIDTH-1:0] row_above_ff;
   logic [MAX_WIDTH-1:0] row_pending_ff;
   logic                 pend_valid_ff;
   logic [MAX_WIDTH-1:0] above_cur;

   assign above_cur = pend_valid_ff ? row_pending_ff : '1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff   <= '1;
         row_pending_ff <= '0;
         pend_valid_ff  <= 1'b0;
      end else if (s1_fire) begin
         if (s1_last_ff) begin
            // bottom row done, back to the top border
            row_above_ff   <= '1;
            row_pending_ff <= '0;
            pend_valid_ff  <= 1'b0;
         end else begin
            row_above_ff   <= above_cur;
            row_pending_ff <= s1_cells_ff;
            pend_valid_ff  <= 1'b1;
         end
      end
   end

   // both possible results of the registered row
   logic [MAX_WIDTH-1:0] res_pend;   // pending row, now that its lower row is here
   logic [MAX_WIDTH-1:0] res_last;   // bottom row against the lower border
   result_type           push0;
   result_type           push1;
   logic [1:0]           push_count;

   assign res_pend = next_row(row_above_ff, row_pending_ff, s1_cells_ff, use_mask,
                              birth_mask_ff, survive_mask_ff);
   assign res_last = next_row(above_cur, s1_cells_ff, '1, use_mask,
                              birth_mask_ff, survive_mask_ff);

   always_comb begin
      push1.cells    = ROW_BITS'(res_last);
      push1.grid_end = 1'b1;
      push1.run_end  = 1'b1;
      if (pend_valid_ff) begin
         push0.cells    = ROW_BITS'(res_pend);
         push0.grid_end = 1'b0;
         push0.run_end  = !s1_last_ff;
      end else begin
         push0 = push1;
      end
      push_count = 2'(pend_valid_ff) + 2'(s1_last_ff);
   end

   // ---------------------------------------------------------------------
   // two-entry result queue, head at entry 0
   // ---------------------------------------------------------------------
   result_type queue_ff [2];
   result_type queue_in [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] count_pop;
   logic       rsp_pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign count_pop = count_ff - 2'(rsp_pop);
   // the row moves on once the queue has room for all of its results
   assign s1_fire   = s1_valid_ff && (3'(push_count) <= 3'd2 - 3'(count_pop));

   always_comb begin
      queue_in[0] = rsp_pop ? queue_ff[1] : queue_ff[0];
      queue_in[1] = queue_ff[1];
      for (int i = 0; i < 2; i++) begin
         if (s1_fire && push_count != 2'd0 && 2'(i) == count_pop) begin
            queue_in[i] = push0;
         end
         if (s1_fire && push_count == 2'd2 && 2'(i) == count_pop + 2'd1) begin
            queue_in[i] = push1;
         end
      end
      count_in = count_pop + (s1_fire ? push_count : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   assign rsp_next_cells = queue_ff[0].cells;
   assign rsp_grid_end   = queue_ff[0].grid_end;
   assign rsp_run_end    = queue_ff[0].run_end;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue over two entries");

   a_first_row_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && push_count == 2'd0 |-> s1_fire)
      else $error("row without results held back");

   a_grid_restart: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> !pend_valid_ff && row_above_ff == '1)
      else $error("grid state not back at top border after bottom row");

   a_grid_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_end |-> rsp_run_end)
      else $error("bottom row result not marked as final");

   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      !s1_fire && rsp_pop |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count out of step with transactions");

endmodule

// File: test/life_like_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_row_checker - scoreboard for the life-like automaton row step
// tracks register writes and accepted row transactions, predicts the next
// generation rows in order and compares every result transaction with them
// ----------------------------------------------------------------------------
module life_like_row_checker
   import lla_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [ROW_BITS-1:0]       req_row_cells,
   input  logic                      req_last_row,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [ROW_BITS-1:0]       rsp_next_cells,
   input  logic                      rsp_grid_end,
   input  logic                      rsp_run_end,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        rows_outstanding
);

   localparam int REPORT_LIMIT = 10;
   localparam int WIDTH_LIMIT  = MAX_WIDTH_DEFAULT;

   logic [WIDTH_REG_BITS-1:0] width_reg    = ROW_WIDTH_RESET;
   logic [RULE_BITS-1:0]      birth_rule   = BIRTH_MASK_RESET;
   logic [RULE_BITS-1:0]      survive_rule = SURVIVE_MASK_RESET;
   logic [ROW_BITS-1:0]       row_above    = '1;
   logic [ROW_BITS-1:0]       row_held     = '0;
   logic                      held_valid   = 1'b0;
   result_type                expected_rows[$];
   int                        failures     = 0;

   function automatic int unsigned effective_width(input logic [WIDTH_REG_BITS-1:0] r);
      if (r == '0) return 1;
      if (32'(r) > WIDTH_LIMIT) return WIDTH_LIMIT;
      return 32'(r);
   endfunction

   // cells outside the used width are alive
   function automatic int unsigned border_cell(input logic [ROW_BITS-1:0] r, input int x,
                                               input int unsigned w);
      if (x < 0 || x >= int'(w)) return 1;
      return 32'(r[x]);
   endfunction

   function automatic logic [ROW_BITS-1:0] next_generation(
      input logic [ROW_BITS-1:0] up, input logic [ROW_BITS-1:0] mid,
      input logic [ROW_BITS-1:0] down, input int unsigned w,
      input logic [RULE_BITS-1:0] born, input logic [RULE_BITS-1:0] keep);
      logic [ROW_BITS-1:0] res;
      int unsigned         count;
      logic [RULE_BITS-1:0] rule;
      res = '0;
      for (int x = 0; x < int'(w); x++) begin
         count = border_cell(up, x - 1, w) + border_cell(up, x, w) + border_cell(up, x + 1, w)
               + border_cell(mid, x - 1, w) + border_cell(mid, x + 1, w)
               + border_cell(down, x - 1, w) + border_cell(down, x, w)
               + border_cell(down, x + 1, w);
         rule = border_cell(mid, x, w) ? keep : born;
         res[x] = rule[count];
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      int unsigned         w;
      logic [ROW_BITS-1:0] row_up;
      result_type          want;
      if (reset) begin
         width_reg    = ROW_WIDTH_RESET;
         birth_rule   = BIRTH_MASK_RESET;
         survive_rule = SURVIVE_MASK_RESET;
         row_above    = '1;
         row_held     = '0;
         held_valid   = 1'b0;
         expected_rows.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_WIDTH:    width_reg    = csr_wdata[WIDTH_REG_BITS-1:0];
               CSR_BIRTH_MASK:   birth_rule   = csr_wdata[RULE_BITS-1:0];
               CSR_SURVIVE_MASK: survive_rule = csr_wdata[RULE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            w = effective_width(width_reg);
            row_up = held_valid ? row_held : '1;
            if (held_valid) begin
               want.cells    = next_generation(row_above, row_held, req_row_cells, w,
                                               birth_rule, survive_rule);
               want.grid_end = 1'b0;
               want.run_end  = !req_last_row;
               expected_rows.push_back(want);
            end
            if (req_last_row) begin
               want.cells    = next_generation(row_up, req_row_cells, '1, w,
                                               birth_rule, survive_rule);
               want.grid_end = 1'b1;
               want.run_end  = 1'b1;
               expected_rows.push_back(want);
               row_above  = '1;
               row_held   = '0;
               held_valid = 1'b0;
            end else begin
               row_above  = row_up;
               row_held   = req_row_cells;
               held_valid = 1'b1;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected result at %0t: next_cells %h grid_end %b run_end %b",
                           $time, rsp_next_cells, rsp_grid_end, rsp_run_end);
            end else begin
               want = expected_rows.pop_front();
               if (want.cells !== rsp_next_cells || want.grid_end !== rsp_grid_end
                   || want.run_end !== rsp_run_end) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"result mismatch at %0t: next_cells exp %h got %h, ",
                               "grid_end exp %b got %b, run_end exp %b got %b"},
                              $time, want.cells, rsp_next_cells, want.grid_end,
                              rsp_grid_end, want.run_end, rsp_run_end);
               end
            end
         end
      end
      mismatch_count   <= failures;
      rows_outstanding <= expected_rows.size();
   end

endmodule

// File: test/life_like_automaton_row_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_row_step_test - stimulus and verdict for the row step
// drives grids of rows under a range of widths and birth/survive rules, with
// random gaps on the row side and random stalls on the result side; the
// checker beside the block predicts and compares every result transaction
// ----------------------------------------------------------------------------
module life_like_automaton_row_step_test;
   import lla_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 5;
   localparam int ROW_TARGET   = 1410;   // last random phase runs past this
   localparam int SETTLE_WAIT  = 4;      // margin after the last predicted result is delivered
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 4_000_000;

   // register index that maps to nothing, writes to it must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   // rule masks: bit n set means n live neighbors apply
   localparam logic [RULE_BITS-1:0] RULE_NONE      = 9'd0;
   localparam logic [RULE_BITS-1:0] RULE_ALL       = 9'h1FF;
   localparam logic [RULE_BITS-1:0] RULE_5678      = 9'd480;
   localparam logic [RULE_BITS-1:0] RULE_345678    = 9'd504;
   localparam logic [RULE_BITS-1:0] RULE_678       = 9'd448;
   localparam logic [RULE_BITS-1:0] RULE_01        = 9'd3;
   localparam logic [RULE_BITS-1:0] LIFE_BIRTH     = 9'd8;
   localparam logic [RULE_BITS-1:0] LIFE_SURVIVE   = 9'd12;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [ROW_BITS-1:0]       req_row_cells = '0;
   logic                      req_last_row  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b1;
   logic [ROW_BITS-1:0]       rsp_next_cells;
   logic                      rsp_grid_end;
   logic                      rsp_run_end;
   logic                      csr_valid     = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index     = CSR_ROW_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;

   int mismatch_count;
   int rows_outstanding;

   int rows_sent      = 0;
   int results_taken  = 0;
   int grid_rows_left = 0;
   bit req_quiet      = 1'b0;
   bit rsp_quiet      = 1'b0;

   life_like_automaton_row_step DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_cells  (req_row_cells),
      .req_last_row   (req_last_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_cells (rsp_next_cells),
      .rsp_grid_end   (rsp_grid_end),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   life_like_row_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_cells    (req_row_cells),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_cells   (rsp_next_cells),
      .rsp_grid_end     (rsp_grid_end),
      .rsp_run_end      (rsp_run_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .rows_outstanding (rows_outstanding)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #TIMEOUT_NS;
      $display("== FAIL ==");
      $finish;
   end

   // idle length per transaction, zero throughout a quiet stretch
   function automatic int unsigned pick_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   // mix of empty, full, sparse, dense and uniform random rows
   function automatic logic [ROW_BITS-1:0] random_row();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         3:       return {$urandom, $urandom} | {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // named rules from the decimal-digit notation, plain life, extremes, random
   function automatic logic [RULE_BITS-1:0] pick_rule();
      case ($urandom_range(0, 11))
         0:       return RULE_NONE;
         1:       return RULE_ALL;
         2:       return RULE_5678;
         3:       return RULE_345678;
         4:       return RULE_678;
         5:       return RULE_01;
         6:       return LIFE_BIRTH;
         7:       return LIFE_SURVIVE;
         default: return RULE_BITS'($urandom_range(0, 511));
      endcase
   endfunction

   // width word with random unused upper bits; covers 0 and values above 64
   function automatic logic [CSR_DATA_BITS-1:0] pick_width_word();
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom_range(0, 511));
      case ($urandom_range(0, 11))
         0:       word[WIDTH_REG_BITS-1:0] = 7'd0;
         1:       word[WIDTH_REG_BITS-1:0] = 7'd1;
         2:       word[WIDTH_REG_BITS-1:0] = 7'd2;
         3:       word[WIDTH_REG_BITS-1:0] = 7'd3;
         4:       word[WIDTH_REG_BITS-1:0] = 7'd63;
         5:       word[WIDTH_REG_BITS-1:0] = 7'd64;
         6:       word[WIDTH_REG_BITS-1:0] = 7'd65;
         7:       word[WIDTH_REG_BITS-1:0] = 7'd127;
         default: ;
      endcase
      return word;
   endfunction

   // mostly short grids, now and then a tall one
   function automatic int pick_height();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
   endfunction

   // one row transaction; valid stays up into the next row when no gap is drawn
   task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic last);
      int unsigned gap;
      if (rows_sent % 50 == 0) req_quiet = ($urandom_range(0, 3) == 0);
      gap = pick_gap(req_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      req_last_row  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rows_sent++;
   endtask

   // register write transaction; the caller drops csr_valid after its last write
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_BITS-1:0] width_word,
                              input logic [RULE_BITS-1:0] born,
                              input logic [RULE_BITS-1:0] keep);
      write_register(CSR_ROW_WIDTH, width_word);
      write_register(CSR_BIRTH_MASK, born);
      write_register(CSR_SURVIVE_MASK, keep);
      csr_valid <= 1'b0;
   endtask

   // block idle: every predicted result delivered, plus room for a held row
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_outstanding != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // result side: random stall before each transaction, with quiet stretches
   always begin : result_sink
      int unsigned hold;
      if (results_taken % 50 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      hold = pick_gap(rsp_quiet);
      rsp_stall <= (hold != 0);
      repeat (hold) @(posedge clock);
      if (hold != 0) rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      results_taken++;
   end

   initial begin : stimulus
      int phase_rows;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rule (born and survive on 5..8 neighbors), full width
      // single-row grids use the alive border above and below
      send_row('0, 1'b1);
      send_row('1, 1'b1);
      send_row({32{2'b10}}, 1'b0);
      send_row({32{2'b01}}, 1'b0);
      send_row(random_row(), 1'b1);

      // one-cell rows, everything dead is born and nothing survives
      settle_block();
      load_config(9'd1, RULE_ALL, RULE_NONE);
      send_row('0, 1'b1);
      send_row('1, 1'b0);
      send_row('0, 1'b1);

      // width zero acts as one
      settle_block();
      load_config(9'd0, LIFE_BIRTH, LIFE_SURVIVE);
      send_row(random_row(), 1'b0);
      send_row(random_row(), 1'b1);

      // width beyond the maximum acts as full width; unmapped index is dropped
      settle_block();
      load_config(9'h1FF, RULE_345678, RULE_678);
      write_register(CSR_UNMAPPED, 9'h0AA);
      csr_valid <= 1'b0;
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b1);

      // width changes while a grid is open: the new width covers all rows of
      // the next result
      settle_block();
      load_config(9'd64, RULE_01, RULE_5678);
      send_row({$urandom, $urandom}, 1'b0);
      settle_block();
      load_config(9'd3, LIFE_BIRTH, LIFE_SURVIVE);
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b1);

      settle_block();
      load_config(9'd2, RULE_ALL, RULE_ALL);
      send_row(64'd1, 1'b1);

      settle_block();
      load_config(9'd65, LIFE_BIRTH, LIFE_SURVIVE);
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b1);

      // random phases; a phase may end mid-grid so the next setting lands on
      // an open grid
      while (rows_sent < ROW_TARGET) begin
         settle_block();
         load_config(pick_width_word(), pick_rule(), pick_rule());
         phase_rows = $urandom_range(20, 80);
         repeat (phase_rows) begin
            if (grid_rows_left == 0) grid_rows_left = pick_height();
            send_row(random_row(), grid_rows_left == 1);
            grid_rows_left--;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
